### sv/small_digit_glyph_renderer_top_assert.svh
// Assertion macros shared by the glyph renderer modules.
// Plain text macros only; no other file is needed.
`ifndef SMALL_DIGIT_GLYPH_RENDERER_TOP_ASSERT_SVH
`define SMALL_DIGIT_GLYPH_RENDERER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDGR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("glyph renderer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SDGR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("glyph renderer assertion failed");

`endif

### sv/sdgr_pkg.sv
// Package for the glyph renderer: types, character codes and the font tables.
// Has no dependencies; used by the controller, datapath and top level.
`default_nettype none

package sdgr_pkg;

	localparam int MAX_CHARS = 32;
	localparam int CHARS_W = 6;

	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DOT = 8'h2E;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	localparam logic [3:0] GLYPH_ONE = 4'd1;
	localparam logic [3:0] GLYPH_FOUR = 4'd4;
	localparam logic [3:0] GLYPH_DOT = 4'd10;

	localparam logic [7:0] SPACE_ADV = 8'd4;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EMIT
	} sdgr_state_t;

	typedef struct packed {
		logic accept;
		logic emit;
	} sdgr_cmd_t;

	typedef struct packed {
		logic draw;
		logic last;
		logic out_free;
	} sdgr_sts_t;

	typedef struct packed {
		logic valid;
		logic [3:0] idx;
	} glyph_sel_t;

	typedef logic [0:15][7:0] glyph_row_t;

	function automatic glyph_sel_t glyph_index(input logic [7:0] code);
		glyph_sel_t sel;
		sel.valid = 1'b0;
		sel.idx = 4'd0;
		if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
			sel.valid = 1'b1;
			sel.idx = 4'(code - CHAR_ZERO);
		end else if (code == CHAR_DOT) begin
			sel.valid = 1'b1;
			sel.idx = GLYPH_DOT;
		end
		return sel;
	endfunction

	// Each entry holds the column in the high nibble and the row in the low nibble.
	function automatic glyph_row_t glyph_row(input logic [3:0] g);
		glyph_row_t row;
		unique case (g)
			4'd0: row = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h10, 8'h17,
				8'h20, 8'h27, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36};
			4'd1: row = '{8'h00, 8'h06, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15,
				8'h16, 8'h17, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
			4'd2: row = '{8'h00, 8'h01, 8'h05, 8'h06, 8'h10, 8'h12, 8'h17, 8'h20,
				8'h23, 8'h27, 8'h30, 8'h34, 8'h35, 8'h36, 8'h00, 8'h00};
			4'd3: row = '{8'h01, 8'h02, 8'h05, 8'h06, 8'h10, 8'h17, 8'h20, 8'h23,
				8'h24, 8'h27, 8'h31, 8'h32, 8'h35, 8'h36, 8'h00, 8'h00};
			4'd4: row = '{8'h02, 8'h03, 8'h12, 8'h14, 8'h22, 8'h25, 8'h26, 8'h30,
				8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h42};
			4'd5: row = '{8'h01, 8'h02, 8'h04, 8'h05, 8'h06, 8'h07, 8'h10, 8'h14,
				8'h17, 8'h20, 8'h24, 8'h27, 8'h31, 8'h32, 8'h33, 8'h37};
			4'd6: row = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h10, 8'h14,
				8'h17, 8'h20, 8'h24, 8'h27, 8'h31, 8'h32, 8'h33, 8'h36};
			4'd7: row = '{8'h00, 8'h01, 8'h06, 8'h07, 8'h12, 8'h13, 8'h17, 8'h24,
				8'h27, 8'h35, 8'h36, 8'h37, 8'h00, 8'h00, 8'h00, 8'h00};
			4'd8: row = '{8'h01, 8'h02, 8'h03, 8'h05, 8'h06, 8'h10, 8'h14, 8'h17,
				8'h20, 8'h24, 8'h27, 8'h31, 8'h32, 8'h33, 8'h35, 8'h36};
			4'd9: row = '{8'h01, 8'h04, 8'h05, 8'h06, 8'h10, 8'h13, 8'h17, 8'h20,
				8'h23, 8'h27, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36};
			GLYPH_DOT: row = '{8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
				8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
			default: row = '0;
		endcase
		return row;
	endfunction

	// Index of the final pixel of each glyph.
	function automatic logic [3:0] glyph_last(input logic [3:0] g);
		logic [3:0] last;
		unique case (g)
			4'd1: last = 4'd10;
			4'd2, 4'd3: last = 4'd13;
			4'd7: last = 4'd11;
			GLYPH_DOT: last = 4'd0;
			default: last = 4'd15;
		endcase
		return last;
	endfunction

	function automatic logic [2:0] glyph_adv(input logic [3:0] g);
		logic [2:0] adv;
		unique case (g)
			GLYPH_ONE: adv = 3'd4;
			GLYPH_FOUR: adv = 3'd6;
			GLYPH_DOT: adv = 3'd3;
			default: adv = 3'd5;
		endcase
		return adv;
	endfunction

endpackage

`default_nettype wire

### sv/small_digit_glyph_renderer_top.sv
// The first pixel of a glyph is registered after the controller enters its emit state.
// A drawn glyph has 1 to 16 pixels; the sequencer issues one pixel per cycle into the
// output register while the output does not stall; the input stalls while it draws.
// Reset is asynchronous and active low: cursor and count clear and the string is ended.
// Top level of the glyph renderer; joins sdgr_ctrl and sdgr_dp and depends on sdgr_pkg.
`default_nettype none

module small_digit_glyph_renderer_top
	import sdgr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        new_string,
	input  wire logic [7:0]  start_x,
	input  wire logic [7:0]  start_y,
	input  wire logic [7:0]  char_code,
	input  wire logic [15:0] color,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [8:0]       pixel_x,
	output logic [8:0]       pixel_y,
	output logic [15:0]      pixel_color,
	output logic             last_pixel
);

	sdgr_cmd_t cmd;
	sdgr_sts_t sts;

	sdgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	sdgr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.new_string  (new_string),
		.start_x     (start_x),
		.start_y     (start_y),
		.char_code   (char_code),
		.color       (color),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel)
	);

endmodule

`default_nettype wire

### sv/sdgr_ctrl.sv
// Controller of the glyph renderer: accepts characters and sequences pixel output.
// Depends on sdgr_pkg and the assertion macro header.
`default_nettype none
`include "small_digit_glyph_renderer_top_assert.svh"

module sdgr_ctrl
	import sdgr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire sdgr_sts_t sts,
	output sdgr_cmd_t      cmd
);

	sdgr_state_t state_q;
	sdgr_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.draw) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free && sts.last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.accept = in_valid;
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: in_stall = 1'b1;
		endcase
	end

	`SDGR_ASSERT_NXT(a_last_returns_idle, clk, arst_n, cmd.emit && sts.last, state_q == ST_IDLE)
	`SDGR_ASSERT_NOW(a_no_emit_on_accept, clk, arst_n, cmd.accept, !cmd.emit)
	`SDGR_ASSERT_NOW(a_stall_while_emit, clk, arst_n, state_q == ST_EMIT, in_stall)

endmodule

`default_nettype wire

### sv/sdgr_dp.sv
// Datapath of the glyph renderer: cursor and string state, font lookup, pixel register.
// Depends on sdgr_pkg and the assertion macro header.
`default_nettype none
`include "small_digit_glyph_renderer_top_assert.svh"

module sdgr_dp
	import sdgr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        new_string,
	input  wire logic [7:0]  start_x,
	input  wire logic [7:0]  start_y,
	input  wire logic [7:0]  char_code,
	input  wire logic [15:0] color,
	input  wire sdgr_cmd_t   cmd,
	output sdgr_sts_t        sts,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [8:0]       pixel_x,
	output logic [8:0]       pixel_y,
	output logic [15:0]      pixel_color,
	output logic             last_pixel
);

	logic [7:0]         cursor_x_q;
	logic [7:0]         cursor_y_q;
	logic [CHARS_W-1:0] chars_q;
	logic               ended_q;
	logic [3:0]         glyph_q;
	logic [3:0]         pix_idx_q;
	logic [15:0]        color_q;
	logic               out_valid_q;

	logic               eff_ended;
	logic [7:0]         eff_x;
	logic [7:0]         eff_y;
	logic [CHARS_W-1:0] eff_chars;
	logic               terminate;
	glyph_sel_t         sel;
	glyph_row_t         row;
	logic [7:0]         entry;
	logic               is_last;
	logic [7:0]         cx_adv;

	assign eff_ended = new_string ? 1'b0 : ended_q;
	assign eff_x = new_string ? start_x : cursor_x_q;
	assign eff_y = new_string ? start_y : cursor_y_q;
	assign eff_chars = new_string ? '0 : chars_q;
	assign terminate = (char_code == CHAR_NUL) || (eff_chars >= CHARS_W'(MAX_CHARS));
	assign sel = glyph_index(char_code);

	assign row = glyph_row(glyph_q);
	assign entry = row[pix_idx_q];
	assign is_last = (pix_idx_q == glyph_last(glyph_q));
	assign cx_adv = cursor_x_q + {5'b0, glyph_adv(glyph_q)};

	assign sts = '{
		draw: !eff_ended && !terminate && sel.valid,
		last: is_last,
		out_free: !out_valid_q || !out_stall
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			chars_q <= '0;
			ended_q <= 1'b1;
			pix_idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (!eff_ended) begin
					cursor_y_q <= eff_y;
					ended_q <= terminate;
					if (terminate) begin
						cursor_x_q <= eff_x;
						chars_q <= eff_chars;
					end else begin
						chars_q <= eff_chars + 1'b1;
						cursor_x_q <= (char_code == CHAR_SPACE) ? eff_x + SPACE_ADV : eff_x;
						pix_idx_q <= '0;
					end
				end
			end else if (cmd.emit) begin
				pix_idx_q <= pix_idx_q + 1'b1;
				if (is_last) begin
					cursor_x_q <= cx_adv;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			glyph_q <= sel.idx;
			color_q <= color;
		end
		if (cmd.emit) begin
			pixel_x <= {1'b0, cursor_x_q} + {5'b0, entry[7:4]};
			pixel_y <= {1'b0, cursor_y_q} + 9'd8 - {5'b0, entry[3:0]};
			pixel_color <= color_q;
			last_pixel <= is_last;
		end
	end

	assign out_valid = out_valid_q;

	`SDGR_ASSERT_NOW(a_idx_in_glyph, clk, arst_n, cmd.emit, pix_idx_q <= glyph_last(glyph_q))
	`SDGR_ASSERT_NXT(a_cursor_advance, clk, arst_n, cmd.emit && is_last, cursor_x_q == $past(cx_adv))
	`SDGR_ASSERT_NOW(a_chars_bounded, clk, arst_n, 1'b1, chars_q <= CHARS_W'(MAX_CHARS))

endmodule

`default_nettype wire
